// ===== sv/iba_pkg.sv =====
package iba_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    localparam logic FUNC_CREATE = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // block size in bytes, a power of two
    localparam int BLOCK_BYTES = 512;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_SRCH_WAIT,
        S_TAKE_IB,
        S_TAKE_DATA,
        S_COMMIT,
        S_GIVE_RD,
        S_GIVE_WAIT,
        S_GIVE_IB,
        S_DONE
    } t_state;

endpackage

// ===== sv/iba_queue.sv =====
// free-block fifo held in a synchronous memory, one pop or push a cycle once the clearing pass is done
module iba_queue #(
    parameter int NUM_BLOCKS = 64,
    parameter int BW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop,
    input  logic          i_push,
    input  logic [BW-1:0] i_push_blk,
    output logic [BW-1:0] o_head_blk,
    output logic          o_busy
);
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    logic [BW-1:0] mem [NUM_BLOCKS];
    logic [BW-1:0] r_head, r_tail, n_head;
    logic [CW-1:0] r_count;
    logic [BW-1:0] r_init_addr;
    logic          r_init;

    // head wraps at NUM_BLOCKS, which need not be a power of two
    always_comb begin
        n_head = r_head;
        if (i_pop) begin
            n_head = (r_head == BW'(NUM_BLOCKS - 1)) ? '0 : r_head + 1'b1;
        end
    end

    // clearing pass after reset writes the ascending block numbers
    always_ff @(posedge i_clk) begin
        if (r_init) begin
            mem[r_init_addr] <= r_init_addr;
        end else if (i_push && r_count != CW'(NUM_BLOCKS)) begin
            mem[r_tail] <= i_push_blk;
        end
        o_head_blk <= mem[n_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= CW'(NUM_BLOCKS);
            r_init      <= 1'b1;
            r_init_addr <= '0;
        end else begin
            if (r_init) begin
                r_init_addr <= r_init_addr + 1'b1;
                if (r_init_addr == BW'(NUM_BLOCKS - 1)) begin
                    r_init <= 1'b0;
                end
            end
            r_head <= n_head;
            if (i_pop) begin
                r_count <= r_count - 1'b1;
            end else if (i_push && r_count != CW'(NUM_BLOCKS)) begin
                r_count <= r_count + 1'b1;
            end
            if (i_push && r_count != CW'(NUM_BLOCKS)) begin
                r_tail <= (r_tail == BW'(NUM_BLOCKS - 1)) ? '0 : r_tail + 1'b1;
            end
        end
    end

    assign o_busy = r_init;

endmodule

// ===== sv/iba_ptr_store.sv =====
// per-file data block lists, NUM_BLOCKS entries under each index block
module iba_ptr_store #(
    parameter int NUM_BLOCKS = 64,
    parameter int BW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [BW-1:0] i_ib,
    input  logic [BW-1:0] i_idx,
    input  logic [BW-1:0] i_wdata,
    output logic [BW-1:0] o_rdata
);
    localparam int AW = 2 * BW;

    logic [BW-1:0] mem [NUM_BLOCKS * NUM_BLOCKS];
    logic [AW-1:0] addr;

    assign addr = AW'(i_ib) * AW'(NUM_BLOCKS) + AW'(i_idx);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[addr] <= i_wdata;
        end
        o_rdata <= mem[addr];
    end

endmodule

// ===== sv/indexed_block_allocator_core.sv =====
// Indexed file block allocator. One item per call: create (func 0) or delete
// (func 1); each yields exactly one result item. Free blocks live in a FIFO
// memory, data block lists in a pointer memory, file entries in a slot memory
// that is scanned one slot at a time. The next item is taken in the cycle after
// the result is loaded, later while an earlier result still waits on the
// receiver. The block size is a power of two held in the package. After reset
// a clearing pass fills the free queue before the first item is taken.
module indexed_block_allocator_core #(
    parameter int NUM_BLOCKS  = 64,
    parameter int FILE_SLOTS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] func, [64:1] file_key, [84:65] size_bytes
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [17:2] file_id, [23:18] index_block,
    // [29:24] data_block_count, [36:30] free_count
    output logic [39:0] m_axis_tdata
);
    import iba_pkg::*;

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int SW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int SCW = $clog2(FILE_SLOTS + 1);
    localparam int NW = $clog2(NUM_BLOCKS + 1);
    localparam int OFF = $clog2(BLOCK_BYTES);
    localparam int IW = 16 + 2 * BW;

    t_state r_state, n_state;

    logic          r_func;
    logic [63:0]   r_key;
    logic [19:0]   r_size;
    logic [NW-1:0] r_free, r_need;
    logic [SCW-1:0] r_files;
    logic [15:0]   r_next_id;
    logic [FILE_SLOTS-1:0] r_used;
    logic [SW-1:0] r_slot;
    logic [SCW-1:0] r_scan;
    logic [BW-1:0] r_ib, r_cnt, r_i;
    logic [15:0]   r_id;
    logic [1:0]    r_status;
    logic          r_ovalid;
    logic [39:0]   r_odata;

    logic [63:0]   slot_key_mem  [FILE_SLOTS];
    logic [IW-1:0] slot_info_mem [FILE_SLOTS];
    logic [63:0]   r_rd_key;
    logic [IW-1:0] r_rd_info;
    logic [SW-1:0] rd_slot;
    logic          slot_we;
    logic          slot_hit;
    logic          create_fail;

    logic          q_pop, q_push, q_busy;
    logic [BW-1:0] q_push_blk, q_head;
    logic          p_we;
    logic [BW-1:0] p_ib, p_idx, p_rdata;
    logic [NW-1:0] need_c;

    // ceil(size / BLOCK_BYTES) by shift, BLOCK_BYTES a power of two
    logic [20:0] need_w;
    assign need_w = (21'(r_size) + 21'(BLOCK_BYTES - 1)) >> OFF;
    assign need_c = NW'(need_w);

    // compare at full width, a large size must not wrap into a small need
    assign create_fail = !r_func && (r_files >= SCW'(FILE_SLOTS)
                                     || need_w + 21'd1 > 21'(r_free));

    iba_queue #(.NUM_BLOCKS(NUM_BLOCKS), .BW(BW)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop      (q_pop),
        .i_push     (q_push),
        .i_push_blk (q_push_blk),
        .o_head_blk (q_head),
        .o_busy     (q_busy)
    );

    iba_ptr_store #(.NUM_BLOCKS(NUM_BLOCKS), .BW(BW)) u_ptr (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_ib    (p_ib),
        .i_idx   (p_idx),
        .i_wdata (q_head),
        .o_rdata (p_rdata)
    );

    assign rd_slot = SW'(r_scan);
    assign slot_we = (r_state == S_COMMIT) && !r_func;

    // create wants the first free slot, delete the first key match
    assign slot_hit = !r_func ? !r_used[rd_slot]
                              : (r_used[rd_slot] && r_rd_key == r_key);

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_key_mem[r_slot]  <= r_key;
            slot_info_mem[r_slot] <= {r_next_id, r_ib, r_cnt};
        end
        r_rd_key  <= slot_key_mem[rd_slot];
        r_rd_info <= slot_info_mem[rd_slot];
    end

    always_comb begin
        n_state    = r_state;
        q_pop      = 1'b0;
        q_push     = 1'b0;
        q_push_blk = p_rdata;
        p_we       = 1'b0;
        p_ib       = r_ib;
        p_idx      = r_i;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && !q_busy) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (create_fail)
                    n_state = S_DONE;
                else
                    n_state = S_SEARCH;
            end
            S_SEARCH: n_state = S_SRCH_WAIT;
            S_SRCH_WAIT: begin
                if (slot_hit) begin
                    n_state = r_func ? S_GIVE_RD : S_TAKE_IB;
                end else if (r_scan == SCW'(FILE_SLOTS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_TAKE_IB: begin
                q_pop = 1'b1;
                n_state = (r_need == '0) ? S_COMMIT : S_TAKE_DATA;
            end
            S_TAKE_DATA: begin
                q_pop = 1'b1;
                p_we  = 1'b1;
                if (NW'(r_i) + 1'b1 == r_need) n_state = S_COMMIT;
            end
            S_COMMIT: n_state = S_DONE;
            S_GIVE_RD: n_state = (r_cnt == '0) ? S_GIVE_IB : S_GIVE_WAIT;
            S_GIVE_WAIT: begin
                q_push = 1'b1;
                if (r_i == r_cnt) n_state = S_GIVE_IB;
                p_idx = r_i;
            end
            S_GIVE_IB: begin
                q_push     = 1'b1;
                q_push_blk = r_ib;
                n_state    = S_COMMIT;
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && !q_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= NW'(NUM_BLOCKS);
            r_files   <= '0;
            r_next_id <= '0;
            r_used    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
                r_odata  <= {3'b000, 7'(r_free), 6'(r_cnt), 6'(r_ib), r_id, r_status};
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_func   <= s_axis_tdata[0];
                    r_key    <= s_axis_tdata[64:1];
                    r_size   <= s_axis_tdata[84:65];
                    r_scan   <= '0;
                    r_status <= ST_OK;
                    r_id     <= '0;
                    r_ib     <= '0;
                    r_cnt    <= '0;
                    r_i      <= '0;
                end
                S_CHECK: begin
                    r_need <= need_c;
                    if (create_fail)
                        r_status <= ST_NO_SPACE;
                end
                S_SEARCH: r_scan <= r_scan;
                S_SRCH_WAIT: begin
                    if (slot_hit) begin
                        r_slot <= rd_slot;
                        if (r_func) begin
                            r_id  <= r_rd_info[IW-1:2*BW];
                            r_ib  <= r_rd_info[2*BW-1:BW];
                            r_cnt <= r_rd_info[BW-1:0];
                        end
                    end else if (r_scan == SCW'(FILE_SLOTS - 1)) begin
                        r_status <= r_func ? ST_NOT_FOUND : ST_NO_SPACE;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_TAKE_IB: begin
                    r_ib   <= q_head;
                    r_cnt  <= BW'(r_need);
                    r_free <= r_free - 1'b1;
                end
                S_TAKE_DATA: begin
                    r_i    <= r_i + 1'b1;
                    r_free <= r_free - 1'b1;
                end
                S_GIVE_RD: r_i <= r_i + 1'b1;
                S_GIVE_WAIT: begin
                    if (r_i != r_cnt) r_i <= r_i + 1'b1;
                    if (r_free != NW'(NUM_BLOCKS)) r_free <= r_free + 1'b1;
                end
                S_GIVE_IB: begin
                    if (r_free != NW'(NUM_BLOCKS)) r_free <= r_free + 1'b1;
                end
                S_COMMIT: begin
                    if (r_func) begin
                        r_used[r_slot] <= 1'b0;
                        if (r_files != '0) r_files <= r_files - 1'b1;
                    end else begin
                        r_used[r_slot] <= 1'b1;
                        r_id      <= r_next_id;
                        r_next_id <= r_next_id + 1'b1;
                        r_files   <= r_files + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n) q_busy |-> !s_axis_tready;
    endproperty
    assert property (p_no_accept_busy) else $error("item accepted during queue fill");

    property p_free_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_free <= NW'(NUM_BLOCKS);
    endproperty
    assert property (p_free_bound) else $error("free count above block total");

    property p_pop_nonempty;
        @(posedge i_clk) disable iff (!i_rst_n) q_pop |-> r_free != '0;
    endproperty
    assert property (p_pop_nonempty) else $error("pop from empty free queue");

endmodule

// ===== test/indexed_block_allocator_core_checker.sv =====
`timescale 1ns / 100ps

module indexed_block_allocator_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    // [0] func, [64:1] file_key, [84:65] size_bytes
    input  logic [87:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    // [1:0] status, [17:2] file_id, [23:18] index_block,
    // [29:24] data_block_count, [36:30] free_count
    input  logic [39:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending
);
    import iba_pkg::*;

    localparam int NBLK = 64;
    localparam int BBYTES = 512;
    localparam int NSLOT = 16;

    typedef struct packed {
        t_status     status;
        logic [15:0] file_id;
        logic [5:0]  ib_num;
        logic [5:0]  data_block_count;
        logic [6:0]  free_count;
    } t_alloc_result;

    logic [5:0]  queue_mem[NBLK];
    int          head_ptr;
    int          tail_ptr;
    int          free_total;
    logic        slot_busy[NSLOT];
    logic [63:0] slot_key[NSLOT];
    logic [15:0] slot_file_id[NSLOT];
    logic [5:0]  slot_ib[NSLOT];
    int          slot_cnt[NSLOT];
    logic [5:0]  block_list[NBLK][NBLK];
    logic [15:0] id_counter;
    int          file_total;
    t_alloc_result expected_results[$];

    function automatic t_alloc_result alloc_apply(logic func, logic [63:0] key,
                                                  logic [19:0] size);
        t_alloc_result r;
        int need;
        int slot;
        logic [5:0] ib;
        r = '{ST_NO_SPACE, 16'd0, 6'd0, 6'd0, 7'd0};
        if (func == FUNC_CREATE) begin
            need = (int'(size) + BBYTES - 1) / BBYTES;
            slot = -1;
            for (int s = NSLOT - 1; s >= 0; s--) if (!slot_busy[s]) slot = s;
            if (file_total < NSLOT && need + 1 <= free_total && slot >= 0) begin
                ib = queue_mem[head_ptr];
                head_ptr = (head_ptr + 1) % NBLK;
                free_total--;
                for (int i = 0; i < need; i++) begin
                    block_list[ib][i] = queue_mem[head_ptr];
                    head_ptr = (head_ptr + 1) % NBLK;
                    free_total--;
                end
                slot_busy[slot] = 1'b1;
                slot_key[slot] = key;
                slot_file_id[slot] = id_counter;
                slot_ib[slot] = ib;
                slot_cnt[slot] = need;
                r = '{ST_OK, id_counter, ib, 6'(need), 7'd0};
                id_counter++;
                file_total++;
            end
        end else begin
            r.status = ST_NOT_FOUND;
            slot = -1;
            for (int s = NSLOT - 1; s >= 0; s--)
                if (slot_busy[s] && slot_key[s] == key) slot = s;
            if (slot >= 0) begin
                for (int i = 0; i <= slot_cnt[slot]; i++) begin
                    if (free_total < NBLK) begin
                        queue_mem[tail_ptr] = (i == slot_cnt[slot]) ?
                            slot_ib[slot] : block_list[slot_ib[slot]][i];
                        tail_ptr = (tail_ptr + 1) % NBLK;
                        free_total++;
                    end
                end
                slot_busy[slot] = 1'b0;
                file_total--;
                r = '{ST_OK, slot_file_id[slot], slot_ib[slot], 6'(slot_cnt[slot]), 7'd0};
            end
        end
        r.free_count = 7'(free_total);
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_alloc_result got;
        t_alloc_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NBLK; i++) queue_mem[i] = 6'(i);
            head_ptr = 0;
            tail_ptr = 0;
            free_total = NBLK;
            for (int s = 0; s < NSLOT; s++) slot_busy[s] = 1'b0;
            id_counter = '0;
            file_total = 0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            // output is checked first; a result never comes in the cycle its item enters
            if (i_out_valid && i_out_ready) begin
                got = '{t_status'(i_out_data[1:0]), i_out_data[17:2], i_out_data[23:18],
                        i_out_data[29:24], i_out_data[36:30]};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $realtime, i_out_data[36:0]);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %h, actual %h",
                                 $realtime, want, got);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(alloc_apply(i_in_data[0], i_in_data[64:1],
                                                       i_in_data[84:65]));
        end
    end

endmodule

// ===== test/indexed_block_allocator_core_test.sv =====
`timescale 1ns / 100ps

module indexed_block_allocator_core_test;
    import iba_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [0] func, [64:1] file_key, [84:65] size_bytes
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [1:0] status, [17:2] file_id, [23:18] index_block,
    // [29:24] data_block_count, [36:30] free_count
    logic [39:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          quiet_cycles;
    logic        calm;
    logic [63:0] key_pool[8];
    logic [63:0] live_keys[$];

    localparam int QUIET_LIMIT = 20000;

    indexed_block_allocator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    indexed_block_allocator_core_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stalls in bursts
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm || $urandom_range(3) != 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("indexed_block_allocator_core_test NOT OK");
            $finish;
        end
    end

    task automatic send_file_op(logic func, logic [63:0] key, logic [19:0] size);
        if (!calm && $urandom_range(5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, size, key, func};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [19:0] pick_size();
        case ($urandom_range(7))
            0: return 20'd0;
            1: return 20'hFFFFF;
            2: return 20'($urandom_range(32767));
            3: return 20'($urandom);
            default: return 20'($urandom_range(4096));
        endcase
    endfunction

    initial begin
        int idx;
        logic [63:0] key;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        calm          = 1'b0;
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero size, one byte, block edges, max size, full table
        send_file_op(FUNC_DELETE, 64'h0, 20'hFFFFF);
        send_file_op(FUNC_CREATE, 64'h0, 20'd0);
        send_file_op(FUNC_CREATE, 64'hFFFF_FFFF_FFFF_FFFF, 20'd1);
        send_file_op(FUNC_CREATE, 64'h1, 20'd512);
        send_file_op(FUNC_CREATE, 64'h2, 20'd513);
        send_file_op(FUNC_CREATE, 64'h3, 20'hFFFFF);
        send_file_op(FUNC_CREATE, 64'h0, 20'd0);
        send_file_op(FUNC_DELETE, 64'h0, 20'hFFFFF);
        send_file_op(FUNC_DELETE, 64'h0, 20'd0);
        send_file_op(FUNC_DELETE, 64'h0, 20'd0);
        send_file_op(FUNC_CREATE, 64'h4, 20'd29696);
        send_file_op(FUNC_CREATE, 64'h5, 20'd1024);
        for (int i = 0; i < 12; i++) send_file_op(FUNC_CREATE, 64'(i + 16), 20'd0);
        for (int i = 0; i < 12; i++) send_file_op(FUNC_DELETE, 64'(i + 16), 20'd0);
        send_file_op(FUNC_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 20'd0);
        send_file_op(FUNC_DELETE, 64'h1, 20'd0);
        send_file_op(FUNC_DELETE, 64'h2, 20'd0);
        send_file_op(FUNC_DELETE, 64'h4, 20'd0);
        send_file_op(FUNC_DELETE, 64'h5, 20'd0);

        // random: mostly creates and deletes of live keys, some misses
        for (int n = 0; n < 1300; n++) begin
            if (n >= 1150) calm = 1'b1;
            idx = $urandom_range(9);
            if (idx < 5 || live_keys.size() == 0) begin
                key = ($urandom_range(3) == 0) ? key_pool[$urandom_range(7)]
                                               : {$urandom, $urandom};
                send_file_op(FUNC_CREATE, key, pick_size());
                live_keys.push_back(key);
                if (live_keys.size() > 40) void'(live_keys.pop_front());
            end else if (idx < 9) begin
                idx = $urandom_range(live_keys.size() - 1);
                send_file_op(FUNC_DELETE, live_keys[idx], 20'($urandom));
                live_keys.delete(idx);
            end else begin
                send_file_op(FUNC_DELETE, {$urandom, $urandom}, 20'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("indexed_block_allocator_core_test OK");
        else
            $display("indexed_block_allocator_core_test NOT OK");
        $finish;
    end

endmodule
